// ===== rtl/wtem_pkg.sv =====
// package for the windowed throughput / eta meter
// holds payload structs, register indexes, controller states and
// controller/datapath command and status types; no dependencies
package wtem_pkg;

  typedef struct packed {
    logic [15:0] elapsed_ms;
    logic [47:0] now_us;
    logic [47:0] current_bytes;
  } in_item_t;

  typedef struct packed {
    logic [30:0] speed_bps;
    logic        speed_valid;
    logic [30:0] eta_s;
    logic        eta_valid;
  } out_item_t;

  localparam logic [2:0] REG_TOTAL_BYTES  = 3'd0;
  localparam logic [2:0] REG_SLOT_INTERVAL = 3'd1;
  localparam logic [2:0] REG_MAX_GROW     = 3'd2;
  localparam logic [2:0] REG_MIN_SHRINK   = 3'd3;
  localparam logic [2:0] REG_ETA_MARGIN   = 3'd4;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [6:0]  PCT_SCALE    = 7'd100;
  localparam logic [30:0] MAX31        = 31'h7fffffff;
  localparam logic signed [17:0] LEFT_MIN = -18'sd131072;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RATIO,
    ST_RATIO_DIV,
    ST_ADVANCE,
    ST_SCAN,
    ST_SPEED,
    ST_SPEED_DIV,
    ST_ETA,
    ST_ETA_MUL,
    ST_ETA_DIV,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_RATIO,
    DIV_SPEED,
    DIV_ETA
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     ratio_setup;
    logic     advance;
    logic     scan_step;
    logic     speed_setup;
    logic     eta_setup;
    logic     mul_step;
    logic     eta_num;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_capture;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic do_advance;
    logic do_ratio;
    logic scan_done;
    logic speed_ok;
    logic eta_ok;
    logic mul_done;
    logic div_busy;
  } dp_status_t;

endpackage

// ===== rtl/wtem_div.sv =====
// restoring divider, one quotient bit per cycle, 31-bit saturating quotient
// depends on wtem_pkg
module wtem_div
  import wtem_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [95:0]  num,
  input  logic [67:0]  den,
  output logic         busy,
  output logic [30:0]  quo
);

  logic [95:0] n;
  logic [68:0] rem;
  logic [30:0] q;
  logic        sat;
  logic [6:0]  cnt;
  logic [68:0] shifted;
  logic        ge;
  logic [31:0] q_ext;

  assign shifted = {rem[67:0], n[95]};
  assign ge      = shifted >= {1'b0, den};
  assign q_ext   = {q, ge};
  assign quo     = sat ? MAX31 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd95;
      n    <= num;
      rem  <= '0;
      q    <= '0;
      sat  <= 1'b0;
    end else if (busy) begin
      n   <= {n[94:0], 1'b0};
      rem <= ge ? shifted - {1'b0, den} : shifted;
      q   <= q_ext[30:0];
      if (q_ext[31]) sat <= 1'b1;
      if (cnt == 7'd0) busy <= 1'b0;
      else cnt <= cnt - 7'd1;
    end
  end

endmodule

// ===== rtl/wtem_ctrl.sv =====
// controller state machine sequencing one item through the datapath
// depends on wtem_pkg
module wtem_ctrl
  import wtem_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_busy_load,
  input  logic       out_free,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_LOAD;
      ST_LOAD: begin
        if (status.do_advance && status.do_ratio) state_next = ST_RATIO;
        else if (status.do_advance) state_next = ST_ADVANCE;
        else state_next = ST_SCAN;
      end
      ST_RATIO:     state_next = ST_RATIO_DIV;
      ST_RATIO_DIV: if (!status.div_busy) state_next = ST_ADVANCE;
      ST_ADVANCE:   state_next = ST_SCAN;
      ST_SCAN:      if (status.scan_done) state_next = ST_SPEED;
      ST_SPEED:     state_next = status.speed_ok ? ST_SPEED_DIV : ST_ETA;
      ST_SPEED_DIV: if (!status.div_busy) state_next = ST_ETA;
      ST_ETA:       state_next = status.eta_ok ? ST_ETA_MUL : ST_OUT;
      ST_ETA_MUL:   if (status.mul_done) state_next = ST_ETA_DIV;
      ST_ETA_DIV:   if (!status.div_busy) state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = DIV_RATIO;
    in_ready = 1'b0;
    out_busy_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_RATIO: begin
        cmd.ratio_setup = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel = DIV_RATIO;
      end
      ST_RATIO_DIV: begin
        cmd.div_sel = DIV_RATIO;
        cmd.div_capture = !status.div_busy;
      end
      ST_ADVANCE: cmd.advance = 1'b1;
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_SPEED: begin
        cmd.speed_setup = 1'b1;
        cmd.div_start = status.speed_ok;
        cmd.div_sel = DIV_SPEED;
      end
      ST_SPEED_DIV: begin
        cmd.div_sel = DIV_SPEED;
        cmd.div_capture = !status.div_busy;
      end
      ST_ETA: begin
        cmd.eta_setup = 1'b1;
        cmd.div_sel = DIV_ETA;
      end
      // product built 16 bits per cycle, then handed to the divider
      ST_ETA_MUL: begin
        cmd.div_sel = DIV_ETA;
        cmd.mul_step = !status.mul_done;
        cmd.eta_num = status.mul_done;
        cmd.div_start = status.mul_done;
      end
      ST_ETA_DIV: begin
        cmd.div_sel = DIV_ETA;
        cmd.div_capture = !status.div_busy;
      end
      ST_OUT: begin
        cmd.out_load = out_free;
        out_busy_load = out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/wtem_dp.sv =====
// datapath: slot ring, config registers, operand setup, shared divider, result
// depends on wtem_pkg and wtem_div
module wtem_dp
  import wtem_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  in_item_t    in_item,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output out_item_t   result
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

  logic [47:0] total_bytes;
  logic [15:0] slot_interval_ms, max_grow_pct, min_shrink_pct, eta_grow_margin_s;

  logic [47:0] slot_time  [NUM_SLOTS];
  logic [47:0] slot_bytes [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_used;
  logic [SW-1:0] newest_slot, base_slot, old_slot;
  logic signed [17:0] interval_left_ms;
  logic signed [32:0] last_eta;
  logic started;

  in_item_t item;
  logic        do_adv, do_ratio;
  logic [SW:0] scan_cnt;

  logic [95:0] div_num;
  logic [67:0] div_den;
  logic        div_busy;
  logic [30:0] div_q;

  logic [30:0] speed, eta;
  logic        speed_ok, eta_ok;

  logic [47:0] mul_a, mul_b;
  logic [95:0] mul_acc;
  logic [1:0]  mul_cnt;
  logic [63:0] mul_part;

  function automatic logic [SW-1:0] inc(input logic [SW-1:0] a);
    return (a == LAST) ? '0 : a + SW'(1);
  endfunction
  function automatic logic [SW-1:0] dec(input logic [SW-1:0] a);
    return (a == '0) ? LAST : a - SW'(1);
  endfunction

  // countdown value for this item
  logic signed [18:0] left_sub;
  logic signed [17:0] left_sat;
  assign left_sub = 19'(interval_left_ms) - 19'(signed'({1'b0, in_item.elapsed_ms}));
  assign left_sat = (left_sub < 19'(LEFT_MIN)) ? LEFT_MIN : left_sub[17:0];

  logic [SW-1:0] prev_slot;
  assign prev_slot = dec(newest_slot);

  logic [47:0] newer_d, older_d;
  assign newer_d = item.current_bytes - slot_bytes[newest_slot];
  assign older_d = slot_bytes[newest_slot] - slot_bytes[prev_slot];

  logic [47:0] bt, bo, tt, to;
  assign tt = slot_time[base_slot];
  assign bt = slot_bytes[base_slot];
  assign to = slot_time[old_slot];
  assign bo = slot_bytes[old_slot];

  logic sp_ok, et_ok;
  assign sp_ok = item.now_us > tt;
  assign et_ok = (total_bytes > item.current_bytes) && (item.now_us > to)
                 && (item.current_bytes > bo);

  // operand products are formed in registers, one multiply per setup cycle
  logic [47:0] sp_diff;
  assign sp_diff = (item.current_bytes > bt) ? item.current_bytes - bt : '0;

  logic [30:0] ratio_q;
  logic [31:0] ratio_ext;
  assign ratio_ext = {1'b0, ratio_q};

  // hysteresis
  logic signed [33:0] r_s, le_s, le_top;
  logic hold;
  assign r_s    = 34'(signed'({3'b000, div_q}));
  assign le_s   = 34'(last_eta);
  assign le_top = le_s + 34'(signed'({1'b0, eta_grow_margin_s}));
  assign hold   = !last_eta[32] && (r_s >= le_s) && (r_s < le_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bytes       <= '0;
      slot_interval_ms  <= 16'd500;
      max_grow_pct      <= 16'd400;
      min_shrink_pct    <= 16'd25;
      eta_grow_margin_s <= 16'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOTAL_BYTES:   total_bytes       <= cfg_data;
        REG_SLOT_INTERVAL: slot_interval_ms  <= cfg_data[15:0];
        REG_MAX_GROW:      max_grow_pct      <= cfg_data[15:0];
        REG_MIN_SHRINK:    min_shrink_pct    <= cfg_data[15:0];
        REG_ETA_MARGIN:    eta_grow_margin_s <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used        <= '0;
      newest_slot      <= '0;
      base_slot        <= '0;
      started          <= 1'b0;
      interval_left_ms <= 18'sd500;
      last_eta         <= -33'sd5;
      do_adv           <= 1'b0;
      do_ratio         <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_time[i]  <= '0;
        slot_bytes[i] <= '0;
      end
    end else begin
      if (cfg_we && cfg_index == REG_SLOT_INTERVAL && !started)
        interval_left_ms <= 18'(signed'({1'b0, cfg_data[15:0]}));
      if (cfg_we && cfg_index == REG_ETA_MARGIN && !started && last_eta[32])
        last_eta <= -33'(signed'({1'b0, cfg_data[15:0]}));
      if (cmd.load) begin
        item <= in_item;
        do_ratio <= slot_used[prev_slot];
        if (!started) begin
          started          <= 1'b1;
          slot_time[0]     <= in_item.now_us;
          slot_bytes[0]    <= in_item.current_bytes;
          slot_used[0]     <= 1'b1;
          newest_slot      <= '0;
          base_slot        <= '0;
          interval_left_ms <= 18'(signed'({1'b0, slot_interval_ms}));
          do_adv           <= 1'b0;
        end else begin
          interval_left_ms <= left_sat;
          do_adv           <= left_sat <= 18'sd0;
        end
      end
      if (cmd.div_capture && cmd.div_sel == DIV_RATIO) begin
        if (ratio_ext >= {16'd0, max_grow_pct} || ratio_ext <= {16'd0, min_shrink_pct})
          base_slot <= newest_slot;
      end
      if (cmd.advance) begin
        interval_left_ms <= interval_left_ms + 18'(signed'({1'b0, slot_interval_ms}));
        newest_slot <= inc(newest_slot);
        slot_bytes[inc(newest_slot)] <= item.current_bytes;
        slot_time[inc(newest_slot)]  <= item.now_us;
        slot_used[inc(newest_slot)]  <= 1'b1;
        if (inc(newest_slot) == base_slot) base_slot <= inc(base_slot);
      end
      if (cmd.div_capture && cmd.div_sel == DIV_ETA && !hold)
        last_eta <= 33'(r_s);
    end
  end

  // oldest used slot search, one slot per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (cmd.advance || cmd.load) begin
      scan_cnt <= '0;
    end else if (cmd.scan_step) begin
      if (scan_cnt == '0) old_slot <= inc(newest_slot);
      else if (!slot_used[old_slot]) old_slot <= inc(old_slot);
      if (!status.scan_done) scan_cnt <= scan_cnt + (SW+1)'(1);
    end
  end

  assign status.scan_done = (scan_cnt != '0) &&
                            (slot_used[old_slot] || scan_cnt == (SW+1)'(NUM_SLOTS));

  // eta numerator: 48 x 48 product, 16 multiplier bits per cycle, msb first
  assign mul_part = mul_a * mul_b[47:32];

  always_ff @(posedge clk) begin
    if (cmd.eta_setup) begin
      mul_a   <= total_bytes - item.current_bytes;
      mul_b   <= item.now_us - to;
      mul_acc <= '0;
      mul_cnt <= '0;
    end else if (cmd.mul_step) begin
      mul_acc <= {mul_acc[79:0], 16'd0} + 96'(mul_part);
      mul_b   <= {mul_b[31:0], 16'd0};
      mul_cnt <= mul_cnt + 2'd1;
    end
  end

  assign status.mul_done = mul_cnt == 2'd3;

  always_ff @(posedge clk) begin
    if (cmd.ratio_setup) begin
      div_num <= 96'(newer_d) * 96'(PCT_SCALE);
      div_den <= 68'(older_d) + 68'd1;
    end else if (cmd.speed_setup) begin
      div_num <= 96'(sp_diff) * 96'(USEC_PER_SEC);
      div_den <= 68'(item.now_us - tt);
    end else if (cmd.eta_setup) begin
      div_den <= 68'(item.current_bytes - bo) * 68'(USEC_PER_SEC);
    end else if (cmd.eta_num) begin
      div_num <= mul_acc;
    end
  end

  // the divider starts in the cycle after setup, via a registered start
  logic div_go;
  always_ff @(posedge clk) begin
    if (rst) div_go <= 1'b0;
    else div_go <= cmd.div_start;
  end

  wtem_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_q)
  );

  assign ratio_q = div_q;
  assign status.div_busy   = div_busy || div_go;
  assign status.do_advance = do_adv;
  assign status.do_ratio   = do_ratio;
  assign status.speed_ok   = sp_ok;
  assign status.eta_ok     = et_ok;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      speed_ok <= 1'b0;
      eta_ok   <= 1'b0;
      speed    <= '0;
      eta      <= '0;
    end
    if (cmd.speed_setup) speed_ok <= sp_ok;
    if (cmd.eta_setup) eta_ok <= et_ok;
    if (cmd.div_capture && cmd.div_sel == DIV_SPEED) speed <= div_q;
    if (cmd.div_capture && cmd.div_sel == DIV_ETA)
      eta <= hold ? last_eta[30:0] : div_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.speed_bps   <= speed;
      result.speed_valid <= speed_ok;
      result.eta_s       <= eta;
      result.eta_valid   <= eta_ok;
    end
  end

endmodule

// ===== rtl/windowed_throughput_eta_meter.sv =====
// windowed throughput and eta meter, top level
// each item runs through load, an optional ratio division and slot advance, the
//   oldest used slot scan, the speed division and the eta product and division,
//   the last two each skipped when their operands are not valid, before out_valid
// one item at a time: the next transfer is accepted the cycle after the result loads
// synchronous reset restores register defaults and clears the slot ring
// depends on wtem_pkg, wtem_ctrl, wtem_dp
module windowed_throughput_eta_meter
  import wtem_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       out_load;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  wtem_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_busy_load (out_load),
    .out_free      (out_free),
    .status        (status),
    .cmd           (cmd)
  );

  wtem_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_data),
    .cmd       (cmd),
    .status    (status),
    .result    (out_data)
  );

endmodule
